@@ rtl/isd_pkg.sv @@
// ----------------------------------------------------------------------------
// isd_pkg
// Shared types and constants for the descending insertion sorter.
// ----------------------------------------------------------------------------
package isd_pkg;

  localparam int VALUE_W       = 32;
  localparam int DEPTH_DEFAULT = 64;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Command broadcast to every cell of the chain in the same cycle.
  typedef struct packed {
    logic insert;  // place the broadcast key, shifting smaller entries down
    logic drain;   // move every entry one place towards the head
  } cell_ctrl_t;

endpackage

@@ rtl/insertion_sort_descending_unit.sv @@
// ----------------------------------------------------------------------------
// insertion_sort_descending_unit
// Keeps a chain of cells ordered from largest to smallest and drains it on
// the item marked last.
// ----------------------------------------------------------------------------
// A non-last item is taken while busy stays low and stored if a cell is free.
// Throughput: one item per cycle while a set is collected.
// A last item moves the unit into its drain state, in which each stored
// entry is registered as a result on consecutive cycles; busy is high until the final result is shown.
// The receiver cannot stall; the chain shifts one place towards its head per
// result. Reset (synchronous) clears the fill count, overflow flag, state and result strobe.
module insertion_sort_descending_unit #(
  parameter int DEPTH = isd_pkg::DEPTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  isd_pkg::value_t     value,
  input  logic                last,
  output logic                busy,
  output logic                res_strobe,
  output isd_pkg::value_t     value_res,
  output logic                last_res,
  output logic                dropped
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  typedef enum logic {IDLE, EMIT} state_t;

  state_t              state;
  logic [FILL_W-1:0]   fill;
  logic                overflow;
  logic                accept;
  logic                room;
  isd_pkg::cell_ctrl_t ctrl;

  logic            keep [DEPTH];
  isd_pkg::value_t vals [DEPTH];

  assign busy   = (state == EMIT);
  assign accept = start && !busy;
  assign room   = (fill < FILL_W'(DEPTH));

  assign ctrl.insert = accept && room;
  assign ctrl.drain  = busy;

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic            prev_keep;
      isd_pkg::value_t prev_val;
      isd_pkg::value_t next_val;

      if (i == 0) begin : g_head
        assign prev_keep = 1'b1;
        assign prev_val  = value;
      end else begin : g_body
        assign prev_keep = keep[i-1];
        assign prev_val  = vals[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign next_val = vals[i];
      end else begin : g_inner
        assign next_val = vals[i+1];
      end

      isd_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .key       (value),
        .occupied  (FILL_W'(i) < fill),
        .prev_keep (prev_keep),
        .prev_val  (prev_val),
        .next_val  (next_val),
        .keep      (keep[i]),
        .val       (vals[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      fill       <= '0;
      overflow   <= 1'b0;
      res_strobe <= 1'b0;
    end else begin
      res_strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            if (room) begin
              fill <= fill + FILL_W'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (last) begin
              state <= EMIT;
            end
          end
        end
        EMIT: begin
          // The head of the chain leaves each cycle; the rest move up.
          res_strobe <= 1'b1;
          value_res  <= vals[0];
          last_res   <= (fill == FILL_W'(1));
          dropped    <= overflow;
          fill       <= fill - FILL_W'(1);
          if (fill == FILL_W'(1)) begin
            state    <= IDLE;
            overflow <= 1'b0;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The chain never holds more entries than it has cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill count exceeds depth");

  // Results only follow a cycle spent draining.
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    res_strobe |-> $past(busy))
    else $error("result without drain");

  // The final result of a set frees the block for the next item.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_strobe && last_res |-> !busy && fill == '0 && !overflow)
    else $error("block not cleared after final result");

  // Draining is never entered with an empty chain.
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> fill != '0)
    else $error("drain with empty chain");

endmodule

@@ rtl/isd_cell.sv @@
// ----------------------------------------------------------------------------
// isd_cell
// One place of the sorted chain: holds a value and compares it with the key.
// ----------------------------------------------------------------------------
module isd_cell (
  input  logic                clk,
  input  isd_pkg::cell_ctrl_t ctrl,
  input  isd_pkg::value_t     key,
  input  logic                occupied,
  input  logic                prev_keep,
  input  isd_pkg::value_t     prev_val,
  input  isd_pkg::value_t     next_val,
  output logic                keep,
  output isd_pkg::value_t     val
);

  // An occupied entry at least as large as the key stays, so equal values
  // keep their arrival order.
  assign keep = occupied && (val >= key);

  always_ff @(posedge clk) begin
    if (ctrl.insert && !keep) begin
      val <= prev_keep ? key : prev_val;
    end else if (ctrl.drain) begin
      val <= next_val;
    end
  end

endmodule

@@ sim/tb_insertion_sort_descending_unit.sv @@
// ----------------------------------------------------------------------------
// tb_insertion_sort_descending_unit
// Self-checking bench for the descending insertion sorter: sets of signed
// values go in one item at a time, and every drained value, its end-of-set
// mark and its overflow flag are checked in order against a behavioural sorter.
// ----------------------------------------------------------------------------
module tb_insertion_sort_descending_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = isd_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_SLACK = 8;

  typedef struct {
    isd_pkg::value_t value;
    logic            last;
    logic            dropped;
  } sorted_out_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  isd_pkg::value_t value = '0;
  logic            last = 1'b0;
  logic            busy;
  logic            res_strobe;
  isd_pkg::value_t value_res;
  logic            last_res;
  logic            dropped;

  // Behavioural sorter: current set in descending order and its overflow flag.
  isd_pkg::value_t kept_values[$];
  logic            set_overflowed;
  sorted_out_t     sorted_pending[$];

  int fail_count;
  int cycle_count;
  int items_sent;
  int sets_sent;
  int overflow_sets;
  int results_checked;
  int sender_idle_pct;

  insertion_sort_descending_unit #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .last      (last),
    .busy      (busy),
    .res_strobe(res_strobe),
    .value_res (value_res),
    .last_res  (last_res),
    .dropped   (dropped)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Insert one accepted value; on the end of a set, queue the drained list.
  task automatic sorter_accept(input isd_pkg::value_t v, input logic is_last);
    int          pos;
    sorted_out_t r;
    if (kept_values.size() >= DEPTH) begin
      set_overflowed = 1'b1;
    end else begin
      pos = kept_values.size();
      while (pos > 0 && kept_values[pos-1] < v) pos--;
      kept_values.insert(pos, v);
    end
    if (is_last) begin
      foreach (kept_values[k]) begin
        r.value   = kept_values[k];
        r.last    = (k == kept_values.size() - 1);
        r.dropped = set_overflowed;
        sorted_pending.push_back(r);
      end
      if (set_overflowed) overflow_sets++;
      sets_sent++;
      kept_values.delete();
      set_overflowed = 1'b0;
    end
  endtask

  // Called at a rising edge; returns after the item is taken and any idle gap.
  task automatic send_item(input isd_pkg::value_t v, input logic is_last);
    start <= 1'b1;
    value <= v;
    last  <= is_last;
    do @(posedge clk); while (busy);
    sorter_accept(v, is_last);
    items_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_sorted_out();
    start <= 1'b0;
    do @(posedge clk); while (sorted_pending.size() != 0 || busy);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  function automatic isd_pkg::value_t pick_value();
    isd_pkg::value_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = '0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      // A narrow range so that equal values meet often.
      1, 2, 3: begin
        v = $urandom_range(0, 8);
        v = v - 4;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    sorted_out_t exp_r;
    if (!rst && res_strobe) begin
      if (sorted_pending.size() == 0) begin
        $error("unexpected result: value_res %0d last_res %0b dropped %0b",
               value_res, last_res, dropped);
        fail_count++;
      end else begin
        exp_r = sorted_pending.pop_front();
        results_checked++;
        if (value_res !== exp_r.value) begin
          $error("value_res: expected %0d, got %0d", exp_r.value, value_res);
          fail_count++;
        end
        if (last_res !== exp_r.last) begin
          $error("last_res: expected %0b, got %0b", exp_r.last, last_res);
          fail_count++;
        end
        if (dropped !== exp_r.dropped) begin
          $error("dropped: expected %0b, got %0b", exp_r.dropped, dropped);
          fail_count++;
        end
      end
    end
  end

  task automatic test_single_element_sets();
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(32'sh8000_0000, 1'b1);
    wait_sorted_out();
  endtask

  task automatic test_extreme_values();
    send_item('0, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b0);
    send_item(32'sh7FFF_FFFE, 1'b1);
    wait_sorted_out();
  endtask

  task automatic test_equal_values();
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(-3, 1'b0);
    send_item(3, 1'b0);
    send_item(-3, 1'b0);
    send_item(3, 1'b1);
    wait_sorted_out();
  endtask

  task automatic test_presorted_orders();
    for (int i = 0; i < 5; i++) send_item(i - 2, i == 4);
    for (int i = 0; i < 4; i++) send_item(100 - i, i == 3);
    wait_sorted_out();
  endtask

  // A set that just fills the store, then one that overflows and ends on a
  // dropped element.
  task automatic test_store_full_and_overflow();
    for (int i = 0; i < DEPTH; i++) send_item(pick_value(), i == DEPTH - 1);
    for (int i = 0; i < DEPTH + 2; i++) send_item(pick_value(), i == DEPTH + 1);
    wait_sorted_out();
  endtask

  task automatic test_random_sets(input int item_budget, input int idle_pct);
    int sent;
    int set_size;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < item_budget) begin
      if ($urandom_range(0, 9) == 0) set_size = $urandom_range(13, 40);
      else set_size = $urandom_range(1, 12);
      if (set_size > item_budget - sent) set_size = item_budget - sent;
      for (int i = 0; i < set_size; i++) send_item(pick_value(), i == set_size - 1);
      sent += set_size;
    end
    wait_sorted_out();
  endtask

  initial begin
    kept_values.delete();
    set_overflowed  = 1'b0;
    fail_count      = 0;
    cycle_count     = 0;
    items_sent      = 0;
    sets_sent       = 0;
    overflow_sets   = 0;
    results_checked = 0;
    sender_idle_pct = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_single_element_sets();
    test_extreme_values();
    test_equal_values();
    test_presorted_orders();
    sender_idle_pct = 8;
    test_store_full_and_overflow();
    test_random_sets(85, 8);
    test_random_sets(85, 67);
    test_random_sets(85, 0);

    $display("Sorted %0d sets from %0d items; %0d results checked, %0d sets overflowed.",
             sets_sent, items_sent, results_checked, overflow_sets);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ insertion_sort_descending_unit.f @@
rtl/isd_pkg.sv
rtl/isd_cell.sv
rtl/insertion_sort_descending_unit.sv
sim/tb_insertion_sort_descending_unit.sv
